FILE: hw/rtl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int unsigned CODE_W       = 16;
	localparam int unsigned LEN_W        = 5;
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned SYM_W        = 8;
	localparam int unsigned TABLE_DEPTH  = 256;
	localparam int unsigned ENTRY_W      = CODE_W + LEN_W;
	localparam int unsigned MAX_CODE_LEN = 16;
	localparam int unsigned CAP_LEN      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int unsigned PEND_W       = BYTE_W - 1;
	localparam int unsigned CNT_W        = 3;
	localparam int unsigned ACC_W        = CODE_W + PEND_W;
	localparam int unsigned FIFO_DEPTH   = 4;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FLUSH  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} entry_t;

	typedef struct packed {
		logic              push0;
		logic              push1;
		logic [BYTE_W-1:0] byte0;
		logic              last0;
		logic [BYTE_W-1:0] byte1;
		logic              last1;
	} push_t;

endpackage

FILE: hw/rtl/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module hcbp_ram #(
	parameter int unsigned WIDTH = 21,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/hcbp_pack.sv
// ----------------------------------------------------------------------------
// hcbp_pack
// Bit packing stage: merges a looked-up code word into the pending bits and
// emits up to two complete bytes per transaction, or one padded flush byte.
// ----------------------------------------------------------------------------
module hcbp_pack (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  hcbp_pkg::kind_t kind_s1,
	input  hcbp_pkg::entry_t entry_s1,
	output hcbp_pkg::push_t push
);

	import hcbp_pkg::*;

	logic [PEND_W-1:0] pend_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PEND_W-1:0] pend_d;
	logic [CNT_W-1:0]  cnt_d;

	logic [ACC_W-1:0]  acc;
	logic [LEN_W-1:0]  total;
	logic [LEN_W-1:0]  rem;
	logic [ACC_W-1:0]  sh0;
	logic [ACC_W-1:0]  sh1;
	logic [PEND_W:0]   mask;
	logic [14:0]       flush_w;

	always_comb begin
		acc     = ({{CODE_W{1'b0}}, pend_q} << entry_s1.len) | {{PEND_W{1'b0}}, entry_s1.code};
		total   = {2'b00, cnt_q} + entry_s1.len;
		sh0     = acc >> (total - LEN_W'(BYTE_W));
		sh1     = acc >> (total - LEN_W'(2 * BYTE_W));
		if (total >= LEN_W'(2 * BYTE_W)) begin
			rem = total - LEN_W'(2 * BYTE_W);
		end else if (total >= LEN_W'(BYTE_W)) begin
			rem = total - LEN_W'(BYTE_W);
		end else begin
			rem = total;
		end
		mask    = ((PEND_W+1)'(1) << rem[CNT_W-1:0]) - (PEND_W+1)'(1);
		flush_w = {8'b0, pend_q} << (4'd8 - {1'b0, cnt_q});
	end

	always_comb begin
		push   = '0;
		pend_d = pend_q;
		cnt_d  = cnt_q;
		case (kind_s1)
			KIND_ENCODE: begin
				if (entry_s1.len != '0) begin
					push.push0 = (total >= LEN_W'(BYTE_W));
					push.push1 = (total >= LEN_W'(2 * BYTE_W));
					push.byte0 = sh0[BYTE_W-1:0];
					push.last0 = (total < LEN_W'(2 * BYTE_W));
					push.byte1 = sh1[BYTE_W-1:0];
					push.last1 = 1'b1;
					pend_d     = acc[PEND_W-1:0] & mask[PEND_W-1:0];
					cnt_d      = rem[CNT_W-1:0];
				end
			end
			KIND_FLUSH: begin
				if (cnt_q != '0) begin
					push.push0 = 1'b1;
					push.byte0 = flush_w[BYTE_W-1:0];
					push.last0 = 1'b1;
					pend_d     = '0;
					cnt_d      = '0;
				end
			end
			default: begin
			end
		endcase
		if (!fire) begin
			push   = '0;
			pend_d = pend_q;
			cnt_d  = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else begin
			pend_q <= pend_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

FILE: hw/rtl/hcbp_ofifo.sv
// ----------------------------------------------------------------------------
// hcbp_ofifo
// Output queue that takes up to two bytes per cycle and drains one when ready.
// ----------------------------------------------------------------------------
module hcbp_ofifo (
	input  logic            clk,
	input  logic            arst_n,
	input  hcbp_pkg::push_t push,
	output logic            space,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            last
);

	import hcbp_pkg::*;

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

	logic [BYTE_W:0]  mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W:0]   cnt_q;
	logic             pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign space     = (cnt_q <= (PTR_W+1)'(FIFO_DEPTH - 2));
	assign out_byte  = mem_q[rp_q][BYTE_W-1:0];
	assign last      = mem_q[rp_q][BYTE_W];

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wp_q] <= {push.last0, push.byte0};
		end
		if (push.push1) begin
			mem_q[wp_q + PTR_W'(1)] <= {push.last1, push.byte1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(push.push0) + PTR_W'(push.push1);
			rp_q  <= rp_q + PTR_W'(pop);
			cnt_q <= cnt_q + (PTR_W+1)'(push.push0) + (PTR_W+1)'(push.push1)
				- (PTR_W+1)'(pop);
		end
	end

endmodule

FILE: hw/rtl/huffman_code_bit_packer_core.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Table-driven Huffman encoder with a 256-entry code table in RAM.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid/in_ready    kind, symbol, code_bits, code_len
// out      out_valid/out_ready  out_byte, last
//
// A transaction is taken every cycle while the output queue has space; the
// code table read is registered when it is accepted and the pack stage
// writes the output queue from that register. The queue drains one byte per
// cycle while out_ready is high, so a run of encodes that each complete
// two bytes is held to the drain rate of the output queue.
// Reset clears the code table at once through per-entry valid flags.
// A stalled output backs up the queue and then the input.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  symbol,
	input  logic [15:0] code_bits,
	input  logic [4:0]  code_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last
);

	import hcbp_pkg::*;

	logic                  s1_v_q;
	kind_t                 kind_s1;
	logic                  hit_s1;
	logic [TABLE_DEPTH-1:0] vld_q;
	logic                  accept;
	logic                  fire;
	logic                  space;
	logic                  we;
	logic                  re;
	logic [LEN_W-1:0]      len_cap;
	logic [CODE_W:0]       code_mask;
	entry_t                wentry;
	entry_t                rentry;
	entry_t                entry_s1;
	push_t                 push;

	assign fire     = s1_v_q && space;
	assign in_ready = !s1_v_q || fire;
	assign accept   = in_valid && in_ready;
	assign we       = accept && (kind == KIND_LOAD);
	assign re       = accept && (kind == KIND_ENCODE);

	always_comb begin
		len_cap     = (code_len > LEN_W'(CAP_LEN)) ? LEN_W'(CAP_LEN) : code_len;
		code_mask   = ((CODE_W+1)'(1) << len_cap) - (CODE_W+1)'(1);
		wentry.len  = len_cap;
		wentry.code = code_bits & code_mask[CODE_W-1:0];
		entry_s1    = hit_s1 ? rentry : '0;
	end

	hcbp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(symbol),
		.wdata(wentry),
		.re   (re),
		.raddr(symbol),
		.rdata(rentry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			kind_s1 <= KIND_LOAD;
			hit_s1  <= 1'b0;
			vld_q   <= '0;
		end else begin
			if (accept) begin
				s1_v_q  <= 1'b1;
				kind_s1 <= kind_t'(kind);
			end else if (fire) begin
				s1_v_q <= 1'b0;
			end
			if (re) begin
				hit_s1 <= vld_q[symbol];
			end
			if (we) begin
				vld_q[symbol] <= 1'b1;
			end
		end
	end

	hcbp_pack u_pack (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.kind_s1 (kind_s1),
		.entry_s1(entry_s1),
		.push    (push)
	);

	hcbp_ofifo u_ofifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space    (space),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.last     (last)
	);

endmodule

FILE: hw/rtl/hcbp_checker.sv
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks for the Huffman code bit packer.
// ----------------------------------------------------------------------------
module hcbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        last
);

	import hcbp_pkg::*;

	// A stalled output transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("output payload changed while stalled");

	// The input only stalls while output bytes are waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty output queue");

	// Output from an empty queue traces back to an accepted non-load transaction.
	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2)
			&& ($past(kind, 2) != KIND_LOAD))
		else $error("output appeared without a producing transaction");

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (.*);

FILE: sim/huffman_code_bit_packer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core_test
// Drives load, encode and flush transactions into the bit packer and checks
// every packed byte and its last flag against a cycle-free model of the code
// table and pending bit register, or typed rows' own bytes. A short table of
// directed rows leads, then random traffic with idle gaps and output stalls.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core_test;

	import hcbp_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1350;
	localparam int IDLE_LIMIT   = 2000;
	localparam int LONG_HOLD    = 200;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  symbol;
		logic [15:0] bits;
		logic [4:0]  len;
		logic        typed;
		logic [1:0]  n;
		logic [7:0]  b0;
		logic        l0;
		logic [7:0]  b1;
		logic        l1;
	} row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} due_t;

	localparam int DIR_ROWS = 26;

	row_t dir_rows [0:DIR_ROWS-1] = '{
		'{KIND_ENCODE, 8'h00, 16'h0000, 5'd0,  1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_FLUSH,  8'h00, 16'h0000, 5'd0,  1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_UNUSED, 8'h00, 16'h0000, 5'd0,  1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_LOAD,   8'hFF, 16'hFFFF, 5'd16, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_ENCODE, 8'hFF, 16'h0000, 5'd0,  1'b1, 2'd2, 8'hFF, 1'b0, 8'hFF, 1'b1},
		'{KIND_LOAD,   8'h00, 16'hFFFF, 5'd31, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_ENCODE, 8'h00, 16'h0000, 5'd0,  1'b1, 2'd2, 8'hFF, 1'b0, 8'hFF, 1'b1},
		'{KIND_LOAD,   8'h01, 16'hFFFF, 5'd3,  1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_ENCODE, 8'h01, 16'h0000, 5'd0,  1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_FLUSH,  8'h00, 16'h0000, 5'd0,  1'b1, 2'd1, 8'hE0, 1'b1, 8'h00, 1'b0},
		'{KIND_FLUSH,  8'h00, 16'h0000, 5'd0,  1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_LOAD,   8'h02, 16'hABCD, 5'd0,  1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_ENCODE, 8'h02, 16'h0000, 5'd0,  1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_LOAD,   8'h03, 16'h0001, 5'd1,  1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_ENCODE, 8'h03, 16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_ENCODE, 8'h00, 16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_LOAD,   8'h80, 16'hAAAA, 5'd17, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_ENCODE, 8'h80, 16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_LOAD,   8'h04, 16'h005A, 5'd8,  1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_ENCODE, 8'h04, 16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_LOAD,   8'h05, 16'h0000, 5'd7,  1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_ENCODE, 8'h05, 16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_FLUSH,  8'h00, 16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_LOAD,   8'hFF, 16'h0000, 5'd0,  1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_ENCODE, 8'hFF, 16'h0000, 5'd0,  1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
		'{KIND_UNUSED, 8'hFF, 16'hFFFF, 5'd31, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [1:0]  kind      = '0;
	logic [7:0]  symbol    = '0;
	logic [15:0] code_bits = '0;
	logic [4:0]  code_len  = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        last;

	logic [CODE_W-1:0] code_mem [TABLE_DEPTH];
	logic [LEN_W-1:0]  len_mem [TABLE_DEPTH];
	logic [PEND_W-1:0] pend_bits = '0;
	int                pend_cnt  = 0;

	due_t bytes_due [$];
	due_t want_byte;
	int   errors       = 0;
	int   results_seen = 0;
	int   item_idx     = 0;
	int   stall_left   = 0;
	bit   long_done    = 1'b0;
	bit   draining     = 1'b0;

	huffman_code_bit_packer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.symbol    (symbol),
		.code_bits (code_bits),
		.code_len  (code_len),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	always #5 clk = ~clk;

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			code_mem[i] = '0;
			len_mem[i]  = '0;
		end
	end

	function automatic void pack_item(input logic [1:0] k, input logic [7:0] s,
			input logic [15:0] cb, input logic [4:0] cl, output int n,
			output logic [1:0][7:0] ob, output logic [1:0] ol);
		logic [LEN_W-1:0]  eff;
		logic [CODE_W:0]   mask;
		logic [ACC_W-1:0]  acc;
		logic [BYTE_W-1:0] part;
		int                total;
		n  = 0;
		ob = '0;
		ol = '0;
		case (k)
			KIND_LOAD: begin
				eff = (cl > CAP_LEN) ? LEN_W'(CAP_LEN) : cl;
				mask = ((CODE_W+1)'(1) << eff) - 1'b1;
				code_mem[s] = cb & mask[CODE_W-1:0];
				len_mem[s] = eff;
			end
			KIND_ENCODE: begin
				if (len_mem[s] != 0) begin
					acc = (ACC_W'(pend_bits) << len_mem[s]) | ACC_W'(code_mem[s]);
					total = pend_cnt + int'(len_mem[s]);
					while (total >= BYTE_W && n < 2) begin
						total -= BYTE_W;
						ob[n] = 8'(acc >> total);
						n++;
					end
					pend_cnt = total;
					pend_bits = PEND_W'(acc & ((ACC_W'(1) << total) - 1'b1));
					if (n > 0)
						ol[n-1] = 1'b1;
				end
			end
			KIND_FLUSH: begin
				if (pend_cnt != 0) begin
					part = {1'b0, pend_bits};
					ob[0] = part << (BYTE_W - pend_cnt);
					ol[0] = 1'b1;
					n = 1;
					pend_bits = '0;
					pend_cnt = 0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if ((item_idx / 50) % 4 == 1)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	task automatic send_item(input logic [1:0] k, input logic [7:0] s,
			input logic [15:0] cb, input logic [4:0] cl, input bit typed, input int tn,
			input logic [1:0][7:0] tb, input logic [1:0] tl);
		int              gap;
		int              n;
		logic [1:0][7:0] ob;
		logic [1:0]      ol;
		gap = pick_gap();
		item_idx++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		symbol    <= s;
		code_bits <= cb;
		code_len  <= cl;
		do
			@(posedge clk);
		while (!in_ready);
		pack_item(k, s, cb, cl, n, ob, ol);
		if (typed) begin
			n  = tn;
			ob = tb;
			ol = tl;
		end
		for (int i = 0; i < n; i++)
			bytes_due.push_back('{data: ob[i], fin: ol[i]});
	endtask

	always @(posedge clk) begin
		if (draining) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (!long_done && results_seen >= 150) begin
			long_done  <= 1'b1;
			stall_left <= LONG_HOLD - 1;
			out_ready  <= 1'b0;
		end else if ((results_seen / 60) % 3 == 0 || $urandom_range(0, 99) < 75) begin
			out_ready <= 1'b1;
		end else begin
			out_ready  <= 1'b0;
			stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
				: $urandom_range(8, 30);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (bytes_due.size() == 0) begin
				report_mismatch("byte with nothing due", out_byte, 8'h00);
			end else begin
				want_byte = bytes_due.pop_front();
				if (out_byte !== want_byte.data)
					report_mismatch("out_byte", out_byte, want_byte.data);
				if (last !== want_byte.fin)
					report_mismatch("last", {7'b0, last}, {7'b0, want_byte.fin});
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int          sent;
		int          r;
		bit          paused;
		logic [1:0]  k;
		logic [7:0]  s;
		logic [15:0] cb;
		logic [4:0]  cl;
		sent   = 0;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_ROWS; i++)
			send_item(dir_rows[i].kind, dir_rows[i].symbol, dir_rows[i].bits,
				dir_rows[i].len, dir_rows[i].typed, int'(dir_rows[i].n),
				{dir_rows[i].b1, dir_rows[i].b0}, {dir_rows[i].l1, dir_rows[i].l0});
		while (sent < RANDOM_ITEMS) begin
			if (!paused && sent == RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (bytes_due.size() != 0)
					@(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 25)
				k = KIND_LOAD;
			else if (r < 85)
				k = KIND_ENCODE;
			else if (r < 97)
				k = KIND_FLUSH;
			else
				k = KIND_UNUSED;
			s  = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
			cb = 16'($urandom);
			r  = $urandom_range(0, 99);
			if (r < 5)
				cl = 5'd0;
			else if (r < 15)
				cl = 5'($urandom_range(17, 31));
			else
				cl = 5'($urandom_range(1, 16));
			send_item(k, s, cb, cl, 1'b0, 0, '0, '0);
			if (k != KIND_UNUSED)
				sent++;
		end
		in_valid <= 1'b0;
		draining <= 1'b1;
		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_ram.sv
hw/rtl/hcbp_pack.sv
hw/rtl/hcbp_ofifo.sv
hw/rtl/huffman_code_bit_packer_core.sv
hw/rtl/hcbp_checker.sv
sim/huffman_code_bit_packer_core_test.sv
